>>> sv/ati_pkg.sv
// Shared types, constants and saturation helper for the air temperature increment block.
// No dependencies; air_temperature_increment and ati_chk refer to this package by scoped names.
package ati_pkg;

    localparam int DW       = 32;
    localparam int XW       = 128;
    localparam int GW       = 28;
    localparam int BGW      = 2 * DW + 2;
    localparam int DIV_LAT  = DW + 3;
    localparam int PIPE_LAT = 17 + 4 * DIV_LAT;

    localparam logic [GW-1:0] G_OVER_CP_RESET = GW'(2619366);

    typedef enum logic {
        CMD_TANGENT = 1'b0,
        CMD_ADJOINT = 1'b1
    } cmd_t;

    typedef struct packed {
        logic                 cmd;
        logic                 is_top;
        logic signed [DW-1:0] h;
        logic signed [DW-1:0] hl_lo;
        logic signed [DW-1:0] hl_hi;
        logic signed [DW-1:0] exner_lo;
        logic signed [DW-1:0] exner_hi;
        logic signed [DW-1:0] theta;
        logic signed [DW-1:0] inc_theta;
        logic signed [DW-1:0] inc_exner_lo;
        logic signed [DW-1:0] inc_exner_hi;
        logic signed [DW-1:0] t_hat;
    } in_t;

    typedef struct packed {
        logic signed [DW-1:0] t_inc;
        logic signed [DW-1:0] theta_hat_add;
        logic signed [DW-1:0] exner_lo_hat_add;
        logic signed [DW-1:0] exner_hi_hat_add;
        logic                 fault;
    } out_t;

    typedef struct packed {
        logic                 adj;
        logic                 top;
        logic                 fault;
        logic signed [DW:0]   dz;
        logic signed [DW:0]   wlo;
        logic signed [DW:0]   whi;
        logic signed [DW-1:0] exlo;
        logic signed [DW-1:0] exhi;
        logic signed [DW-1:0] th;
        logic signed [DW-1:0] ith;
        logic signed [DW-1:0] iexlo;
        logic signed [DW-1:0] iexhi;
        logic signed [DW-1:0] that;
        logic signed [DW:0]   d;
        logic signed [DW-1:0] tha;
        logic signed [DW-1:0] elo;
        logic signed [DW-1:0] ehi;
    } ctx_t;

    function automatic logic signed [DW-1:0] sat_dw(input logic signed [DW+1:0] x);
        logic signed [DW+1:0] hi_lim;
        logic signed [DW+1:0] lo_lim;
        hi_lim = {3'b000, {(DW-1){1'b1}}};
        lo_lim = {3'b111, {(DW-1){1'b0}}};
        if (x > hi_lim)
            return hi_lim[DW-1:0];
        if (x < lo_lim)
            return lo_lim[DW-1:0];
        return x[DW-1:0];
    endfunction

endpackage

>>> sv/ati_dly.sv
// Fixed-length delay line for side data that rides alongside the arithmetic units.
// Generic; no package dependencies.
module ati_dly #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic [WIDTH-1:0] d,
    output logic [WIDTH-1:0] q
);

    logic [WIDTH-1:0] sr_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        sr_reg[0] <= d;
        for (int k = 1; k < DEPTH; k++)
        begin
            sr_reg[k] <= sr_reg[k-1];
        end
    end

    assign q = sr_reg[DEPTH-1];

endmodule

>>> sv/ati_mul.sv
// Two-stage signed multiplier: split product of the wide operand, then recombine.
// Generic; no package dependencies.
module ati_mul #(
    parameter int AW = 32,
    parameter int BW = 32
) (
    input  logic                   clk,
    input  logic signed [AW-1:0]   a,
    input  logic signed [BW-1:0]   b,
    output logic signed [AW+BW-1:0] p
);

    localparam int LW = AW / 2;
    localparam int HW = AW - LW;

    logic signed [LW+BW:0]    pl_reg;
    logic signed [HW+BW-1:0]  ph_reg;
    logic signed [AW+BW-1:0]  p_reg;

    always_ff @(posedge clk)
    begin
        pl_reg <= $signed({1'b0, a[LW-1:0]}) * b;
        ph_reg <= $signed(a[AW-1:LW]) * b;
        p_reg  <= ((AW+BW)'(ph_reg) <<< LW) + (AW+BW)'(pl_reg);
    end

    assign p = p_reg;

endmodule

>>> sv/ati_div.sv
// Pipelined signed divider, round to nearest (ties away), saturated to QW bits.
// One quotient bit per stage. Generic; no package dependencies.
module ati_div #(
    parameter int NW = 128,
    parameter int QW = 32
) (
    input  logic                 clk,
    input  logic signed [NW-1:0] num,
    input  logic signed [NW-1:0] den,
    output logic signed [QW-1:0] quo
);

    logic [NW-1:0] a_nmag_reg;
    logic [NW-1:0] a_dmag_reg;
    logic          a_neg_reg;

    logic [NW-1:0] r_reg  [QW+1];
    logic [QW-1:0] nl_reg [QW+1];
    logic [QW-1:0] q_reg  [QW+1];
    logic [NW-1:0] d_reg  [QW+1];
    logic          neg_reg  [QW+1];
    logic          zero_reg [QW+1];
    logic          ovf_reg  [QW+1];

    logic [NW:0]   rs   [QW];
    logic [NW:0]   diff [QW];
    logic          ge   [QW];

    logic [NW-1:0] b_n;
    logic [QW-1:0] lim;
    logic [QW-1:0] mag;
    logic signed [QW-1:0] quo_reg;

    assign b_n = a_nmag_reg + (a_dmag_reg >> 1);

    always_comb
    begin
        for (int i = 0; i < QW; i++)
        begin
            rs[i]   = {r_reg[i], nl_reg[i][QW-1]};
            diff[i] = rs[i] - {1'b0, d_reg[i]};
            ge[i]   = (rs[i] >= {1'b0, d_reg[i]});
        end
    end

    always_comb
    begin
        lim = neg_reg[QW] ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
        if (ovf_reg[QW] || (q_reg[QW] > lim))
            mag = lim;
        else
            mag = q_reg[QW];
    end

    always_ff @(posedge clk)
    begin
        a_nmag_reg <= num[NW-1] ? ($unsigned(~num) + 1'b1) : $unsigned(num);
        a_dmag_reg <= den[NW-1] ? ($unsigned(~den) + 1'b1) : $unsigned(den);
        a_neg_reg  <= num[NW-1] ^ den[NW-1];

        r_reg[0]    <= {{QW{1'b0}}, b_n[NW-1:QW]};
        nl_reg[0]   <= b_n[QW-1:0];
        q_reg[0]    <= '0;
        d_reg[0]    <= a_dmag_reg;
        neg_reg[0]  <= a_neg_reg;
        zero_reg[0] <= (a_dmag_reg == '0);
        ovf_reg[0]  <= ({{QW{1'b0}}, b_n} >= {a_dmag_reg, {QW{1'b0}}});

        for (int i = 0; i < QW; i++)
        begin
            r_reg[i+1]    <= ge[i] ? diff[i][NW-1:0] : rs[i][NW-1:0];
            nl_reg[i+1]   <= nl_reg[i] << 1;
            q_reg[i+1]    <= {q_reg[i][QW-2:0], ge[i]};
            d_reg[i+1]    <= d_reg[i];
            neg_reg[i+1]  <= neg_reg[i];
            zero_reg[i+1] <= zero_reg[i];
            ovf_reg[i+1]  <= ovf_reg[i];
        end

        if (zero_reg[QW])
            quo_reg <= '0;
        else if (neg_reg[QW])
            quo_reg <= ~mag + 1'b1;
        else
            quo_reg <= mag;
    end

    assign quo = quo_reg;

endmodule

>>> sv/air_temperature_increment.sv
// Air temperature increment, tangent-linear and adjoint, one model level per word.
// The path runs through four chained 128-bit divider levels that resolve one quotient bit
// per stage. Throughput: one word per cycle.
// busy stays low and the receiver cannot stall; done strobes each result for one cycle.
// Reset clears the valid line and loads g_over_cp with its default.
// Depends on ati_pkg, ati_dly, ati_mul and ati_div.
module air_temperature_increment (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  ati_pkg::in_t               item,
    output logic                       done,
    output ati_pkg::out_t              result,
    input  logic                       cfg_wr,
    input  logic [ati_pkg::GW-1:0]     cfg_data
);

    localparam int DW  = ati_pkg::DW;
    localparam int XW  = ati_pkg::XW;
    localparam int GW  = ati_pkg::GW;
    localparam int BGW = ati_pkg::BGW;
    localparam int DL  = ati_pkg::DIV_LAT;
    localparam int PL  = ati_pkg::PIPE_LAT;
    localparam int CW  = $bits(ati_pkg::ctx_t);

    logic [GW-1:0]   g_reg;
    logic            vld_reg [PL];
    ati_pkg::in_t    in_reg;
    ati_pkg::out_t   result_reg;
    ati_pkg::out_t   result_next;

    ati_pkg::ctx_t   c1_reg, c1_next;
    ati_pkg::ctx_t   c2, c3, c4, c5, c6, c7, c8, c9, c10;
    ati_pkg::ctx_t   ce_reg, ce_next;
    ati_pkg::ctx_t   cf_reg, cf_next;
    ati_pkg::ctx_t   ch_reg;
    ati_pkg::ctx_t   cj_reg;
    ati_pkg::ctx_t   ck;

    logic signed [DW+GW+1:0] p_g;
    logic signed [2*DW:0]    p_d;
    logic signed [2*DW:0]    p_e;
    logic signed [DW-1:0]    q1, q2, qa, qb, qc, qd;

    logic signed [2*DW:0]    m1, m2, m3, m4;
    logic signed [2*DW-1:0]  m5;
    logic signed [BGW-1:0]   bg_reg, inc_reg;
    logic signed [2*DW-1:0]  tt_reg;
    logic signed [BGW+DW-1:0] n1, n2, n3;
    logic signed [3*DW:0]    n4, n5;

    logic signed [XW-1:0]    num_a_reg, num_b_reg, num_c_reg;
    logic signed [XW-1:0]    den_a_reg, den_bc_reg;

    logic signed [DW-1:0]    ext;

    // configuration and valid line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g_reg <= ati_pkg::G_OVER_CP_RESET;
            for (int k = 0; k < PL; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else
        begin
            if (cfg_wr)
                g_reg <= cfg_data;
            vld_reg[0] <= start;
            for (int k = 1; k < PL; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // geometry and fault
    always_comb
    begin
        c1_next       = '0;
        c1_next.adj   = (in_reg.cmd == ati_pkg::CMD_ADJOINT);
        c1_next.top   = in_reg.is_top;
        c1_next.dz    = (DW+1)'(in_reg.hl_hi) - (DW+1)'(in_reg.hl_lo);
        c1_next.wlo   = (DW+1)'(in_reg.h) - (DW+1)'(in_reg.hl_lo);
        c1_next.whi   = (DW+1)'(in_reg.hl_hi) - (DW+1)'(in_reg.h);
        c1_next.exlo  = in_reg.exner_lo;
        c1_next.exhi  = in_reg.exner_hi;
        c1_next.th    = in_reg.theta;
        c1_next.ith   = in_reg.inc_theta;
        c1_next.iexlo = in_reg.inc_exner_lo;
        c1_next.iexhi = in_reg.inc_exner_hi;
        c1_next.that  = in_reg.t_hat;
        c1_next.fault = (c1_next.dz == '0) || (in_reg.is_top && (in_reg.theta == '0));
    end

    always_ff @(posedge clk)
    begin
        in_reg <= item;
        c1_reg <= c1_next;
    end

    // hydrostatic extrapolation: q = g_over_cp*dz/theta
    ati_mul #(.AW(DW+1), .BW(GW+1)) u_mul_g (
        .clk (clk),
        .a   (c1_reg.dz),
        .b   ($signed({1'b0, g_reg})),
        .p   (p_g)
    );
    ati_dly #(.WIDTH(CW), .DEPTH(2)) u_dly_c2 (.clk(clk), .d(c1_reg), .q(c2));

    ati_div #(.NW(XW), .QW(DW)) u_div_1 (
        .clk (clk),
        .num (XW'(p_g) <<< 6),
        .den (XW'(c2.th)),
        .quo (q1)
    );
    ati_dly #(.WIDTH(CW), .DEPTH(DL)) u_dly_c3 (.clk(clk), .d(c2), .q(c3));

    always_comb
    begin
        ce_next = c3;
        ext     = ati_pkg::sat_dw((DW+2)'(c3.exlo) - (DW+2)'(q1));
        if (c3.top)
        begin
            ce_next.d    = (DW+1)'(c3.exlo) - (DW+1)'(ext);
            ce_next.exhi = ext;
        end
        else
        begin
            ce_next.d = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        ce_reg <= ce_next;
    end

    // top increment: inc_exner_lo + inc_theta*d/theta
    ati_mul #(.AW(DW+1), .BW(DW)) u_mul_d (
        .clk (clk),
        .a   (ce_reg.d),
        .b   (ce_reg.ith),
        .p   (p_d)
    );
    ati_dly #(.WIDTH(CW), .DEPTH(2)) u_dly_c4 (.clk(clk), .d(ce_reg), .q(c4));

    ati_div #(.NW(XW), .QW(DW)) u_div_2 (
        .clk (clk),
        .num (XW'(p_d)),
        .den (XW'(c4.th)),
        .quo (q2)
    );
    ati_dly #(.WIDTH(CW), .DEPTH(DL)) u_dly_c5 (.clk(clk), .d(c4), .q(c5));

    always_comb
    begin
        cf_next = c5;
        if (c5.top)
            cf_next.iexhi = ati_pkg::sat_dw((DW+2)'(c5.iexlo) + (DW+2)'(q2));
    end

    always_ff @(posedge clk)
    begin
        cf_reg <= cf_next;
    end

    // weighted background and increment sums
    ati_mul #(.AW(DW+1), .BW(DW)) u_mul_m1 (.clk(clk), .a(cf_reg.wlo), .b(cf_reg.exhi),  .p(m1));
    ati_mul #(.AW(DW+1), .BW(DW)) u_mul_m2 (.clk(clk), .a(cf_reg.whi), .b(cf_reg.exlo),  .p(m2));
    ati_mul #(.AW(DW+1), .BW(DW)) u_mul_m3 (.clk(clk), .a(cf_reg.wlo), .b(cf_reg.iexhi), .p(m3));
    ati_mul #(.AW(DW+1), .BW(DW)) u_mul_m4 (.clk(clk), .a(cf_reg.whi), .b(cf_reg.iexlo), .p(m4));
    ati_mul #(.AW(DW),   .BW(DW)) u_mul_m5 (.clk(clk), .a(cf_reg.that), .b(cf_reg.th),  .p(m5));
    ati_dly #(.WIDTH(CW), .DEPTH(2)) u_dly_c6 (.clk(clk), .d(cf_reg), .q(c6));

    always_ff @(posedge clk)
    begin
        bg_reg  <= BGW'(m1) + BGW'(m2);
        inc_reg <= BGW'(m3) + BGW'(m4);
        tt_reg  <= m5;
        ch_reg  <= c6;
    end

    ati_mul #(.AW(BGW), .BW(DW))   u_mul_n1 (.clk(clk), .a(bg_reg),  .b(ch_reg.ith),  .p(n1));
    ati_mul #(.AW(BGW), .BW(DW))   u_mul_n2 (.clk(clk), .a(inc_reg), .b(ch_reg.th),   .p(n2));
    ati_mul #(.AW(BGW), .BW(DW))   u_mul_n3 (.clk(clk), .a(bg_reg),  .b(ch_reg.that), .p(n3));
    ati_mul #(.AW(2*DW), .BW(DW+1)) u_mul_n4 (.clk(clk), .a(tt_reg), .b(ch_reg.wlo),  .p(n4));
    ati_mul #(.AW(2*DW), .BW(DW+1)) u_mul_n5 (.clk(clk), .a(tt_reg), .b(ch_reg.whi),  .p(n5));
    ati_dly #(.WIDTH(CW), .DEPTH(2)) u_dly_c7 (.clk(clk), .d(ch_reg), .q(c7));

    always_ff @(posedge clk)
    begin
        if (c7.adj)
            num_a_reg <= XW'(n3);
        else
            num_a_reg <= XW'(n1) + XW'(n2);
        num_b_reg  <= XW'(n4);
        num_c_reg  <= XW'(n5);
        den_a_reg  <= XW'(c7.dz) <<< 28;
        den_bc_reg <= XW'(c7.dz) <<< 12;
        cj_reg     <= c7;
    end

    ati_div #(.NW(XW), .QW(DW)) u_div_a (.clk(clk), .num(num_a_reg), .den(den_a_reg),  .quo(qa));
    ati_div #(.NW(XW), .QW(DW)) u_div_b (.clk(clk), .num(num_b_reg), .den(den_bc_reg), .quo(qb));
    ati_div #(.NW(XW), .QW(DW)) u_div_c (.clk(clk), .num(num_c_reg), .den(den_bc_reg), .quo(qc));
    ati_dly #(.WIDTH(CW), .DEPTH(DL)) u_dly_c8 (.clk(clk), .d(cj_reg), .q(c8));

    always_comb
    begin
        ck     = c8;
        ck.tha = qa;
        ck.ehi = qb;
        ck.elo = qc;
    end

    // fold upper Exner adjoint into theta at the top
    ati_mul #(.AW(DW+1), .BW(DW)) u_mul_e (
        .clk (clk),
        .a   (ck.d),
        .b   (ck.ehi),
        .p   (p_e)
    );
    ati_dly #(.WIDTH(CW), .DEPTH(2)) u_dly_c9 (.clk(clk), .d(ck), .q(c9));

    ati_div #(.NW(XW), .QW(DW)) u_div_d (
        .clk (clk),
        .num (XW'(p_e)),
        .den (XW'(c9.th) <<< 16),
        .quo (qd)
    );
    ati_dly #(.WIDTH(CW), .DEPTH(DL)) u_dly_c10 (.clk(clk), .d(c9), .q(c10));

    always_comb
    begin
        result_next = '0;
        if (c10.fault)
        begin
            result_next.fault = 1'b1;
        end
        else if (!c10.adj)
        begin
            result_next.t_inc = c10.tha;
        end
        else if (c10.top)
        begin
            result_next.theta_hat_add    = ati_pkg::sat_dw((DW+2)'(c10.tha) + (DW+2)'(qd));
            result_next.exner_lo_hat_add = ati_pkg::sat_dw((DW+2)'(c10.elo) + (DW+2)'(c10.ehi));
        end
        else
        begin
            result_next.theta_hat_add    = c10.tha;
            result_next.exner_lo_hat_add = c10.elo;
            result_next.exner_hi_hat_add = c10.ehi;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign busy   = 1'b0;
    assign done   = vld_reg[PL-1];
    assign result = result_reg;

endmodule

>>> sv/ati_chk.sv
// Port-level checker for air_temperature_increment, attached by bind.
// Depends on ati_pkg for the payload types and the pipeline latency.
module ati_chk (
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input logic          busy,
    input logic          done,
    input ati_pkg::out_t result
);

    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !done)
        else $error("done during reset");

    a_done_has_word: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, ati_pkg::PIPE_LAT))
        else $error("result without a matching accepted word");

    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.fault) |-> (result.t_inc == '0 && result.theta_hat_add == '0
            && result.exner_lo_hat_add == '0 && result.exner_hi_hat_add == '0))
        else $error("fault result carries data");

    a_mode_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.t_inc != '0) |-> (result.theta_hat_add == '0
            && result.exner_lo_hat_add == '0 && result.exner_hi_hat_add == '0))
        else $error("tangent and adjoint fields both set");

endmodule

bind air_temperature_increment ati_chk u_ati_chk (.*);

>>> bench/tb.sv
// Self-checking bench for air_temperature_increment: directed and random level words in both modes.
// Predicts each result with 128-bit arithmetic; depends on ati_pkg and the block RTL.
`timescale 1ns / 100ps

module tb;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DW = ati_pkg::DW;
    localparam int GW = ati_pkg::GW;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    ati_pkg::in_t          item;
    logic                  done;
    ati_pkg::out_t         result;
    logic                  cfg_wr;
    logic [GW-1:0]         cfg_data;

    logic [GW-1:0]         g_model;
    ati_pkg::out_t         expected_words[$];
    int                    mismatches;
    int                    words_sent;
    int                    words_checked;
    int                    faults_seen;
    int                    cycles;

    typedef logic signed [127:0] wide_t;

    air_temperature_increment DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .item     (item),
        .done     (done),
        .result   (result),
        .cfg_wr   (cfg_wr),
        .cfg_data (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic signed [DW-1:0] clamp(input wide_t x);
        wide_t hi_lim;
        wide_t lo_lim;
        hi_lim = (wide_t'(1) <<< (DW - 1)) - 1;
        lo_lim = -(wide_t'(1) <<< (DW - 1));
        if (x > hi_lim)
            return hi_lim[DW-1:0];
        if (x < lo_lim)
            return lo_lim[DW-1:0];
        return x[DW-1:0];
    endfunction

    function automatic logic signed [DW-1:0] round_div(input wide_t num, input wide_t den);
        logic [127:0] n;
        logic [127:0] d;
        logic [127:0] q;
        logic         neg;
        if (den == 0)
            return '0;
        neg = (num < 0) != (den < 0);
        n = (num < 0) ? -num : num;
        d = (den < 0) ? -den : den;
        q = (n + (d >> 1)) / d;
        return clamp(neg ? -wide_t'(q) : wide_t'(q));
    endfunction

    function automatic ati_pkg::out_t temperature_of(input ati_pkg::in_t w,
                                                     input logic [GW-1:0] g);
        ati_pkg::out_t r;
        wide_t h, hlo, hhi, dz, wlo, whi;
        wide_t exlo, exhi, th, ith, iexlo, iexhi, that;
        wide_t d, bg, inc, tt, ext, gg;
        logic signed [DW-1:0] tha, elo, ehi, extra;
        r = '0;
        h = w.h; hlo = w.hl_lo; hhi = w.hl_hi;
        exlo = w.exner_lo; exhi = w.exner_hi; th = w.theta;
        ith = w.inc_theta; iexlo = w.inc_exner_lo; iexhi = w.inc_exner_hi;
        that = w.t_hat;
        gg = {100'b0, g};
        dz = hhi - hlo; wlo = h - hlo; whi = hhi - h;
        d = 0;
        if (dz == 0 || (w.is_top && th == 0))
        begin
            r.fault = 1'b1;
            return r;
        end
        if (w.is_top)
        begin
            ext = clamp(exlo - wide_t'(round_div((gg * dz) <<< 6, th)));
            d = exlo - ext;
            exhi = ext;
            iexhi = clamp(iexlo + wide_t'(round_div(ith * d, th)));
        end
        bg = wlo * exhi + whi * exlo;
        if (w.cmd == ati_pkg::CMD_TANGENT)
        begin
            inc = wlo * iexhi + whi * iexlo;
            r.t_inc = round_div(bg * ith + inc * th, dz <<< 28);
        end
        else
        begin
            tt = that * th;
            tha = round_div(bg * that, dz <<< 28);
            ehi = round_div(wlo * tt, dz <<< 12);
            elo = round_div(whi * tt, dz <<< 12);
            if (w.is_top)
            begin
                extra = round_div(wide_t'(ehi) * d, th <<< 16);
                tha = clamp(wide_t'(tha) + wide_t'(extra));
                elo = clamp(wide_t'(elo) + wide_t'(ehi));
                ehi = '0;
            end
            r.theta_hat_add = tha;
            r.exner_lo_hat_add = elo;
            r.exner_hi_hat_add = ehi;
        end
        return r;
    endfunction

    // Hold start until the word is taken; the caller decides whether it drops.
    task automatic send_word(input ati_pkg::in_t w);
        start <= 1'b1;
        item <= w;
        do
            @(posedge clk);
        while (busy);
        expected_words.push_back(temperature_of(w, g_model));
        words_sent++;
    endtask

    task automatic drain();
        start <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (ati_pkg::PIPE_LAT + 10) @(posedge clk);
    endtask

    task automatic write_g(input logic [GW-1:0] v);
        cfg_wr <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_wr <= 1'b0;
        g_model = v;
        @(posedge clk);
    endtask

    function automatic logic signed [DW-1:0] rnd32();
        return $urandom();
    endfunction

    function automatic ati_pkg::in_t realistic_word();
        ati_pkg::in_t w;
        int  base;
        w = '0;
        w.cmd = 1'($urandom_range(0, 1));
        w.is_top = ($urandom_range(0, 3) == 0);
        base = $urandom_range(0, 60000) - 5000;
        w.hl_lo = base <<< 14;
        w.hl_hi = (base + $urandom_range(1, 2000)) <<< 14;
        w.h = w.hl_lo + $signed($urandom_range(0, 32'(w.hl_hi - w.hl_lo)));
        w.exner_lo = $urandom_range(80000000, 280000000);
        w.exner_hi = w.exner_lo - $signed($urandom_range(0, 20000000));
        w.theta = $urandom_range(180 << 20, 500 << 20);
        w.inc_theta = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
        w.inc_exner_lo = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
        w.inc_exner_hi = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
        w.t_hat = $signed($urandom_range(0, 1 << 24)) - (1 << 23);
        case ($urandom_range(0, 19))
            0: w.hl_hi = w.hl_lo;
            1: w.theta = '0;
            2: w.t_hat = rnd32();
            default: ;
        endcase
        return w;
    endfunction

    function automatic ati_pkg::in_t noise_word();
        ati_pkg::in_t w;
        w.cmd = 1'($urandom_range(0, 1));
        w.is_top = 1'($urandom_range(0, 1));
        w.h = rnd32(); w.hl_lo = rnd32(); w.hl_hi = rnd32();
        w.exner_lo = rnd32(); w.exner_hi = rnd32(); w.theta = rnd32();
        w.inc_theta = rnd32(); w.inc_exner_lo = rnd32(); w.inc_exner_hi = rnd32();
        w.t_hat = rnd32();
        if ($urandom_range(0, 7) == 0)
            w.hl_hi = w.hl_lo;
        return w;
    endfunction

    task automatic test_directed();
        ati_pkg::in_t w;
        ati_pkg::in_t base;
        logic signed [DW-1:0] maxv;
        logic signed [DW-1:0] minv;
        maxv = {1'b0, {(DW-1){1'b1}}};
        minv = {1'b1, {(DW-1){1'b0}}};
        base = '0;
        base.hl_lo = 100 <<< 14;
        base.hl_hi = 300 <<< 14;
        base.h = 180 <<< 14;
        base.exner_lo = 32'd250000000;
        base.exner_hi = 32'd245000000;
        base.theta = 300 <<< 20;
        base.inc_theta = 1 <<< 18;
        base.inc_exner_lo = 32'd100000;
        base.inc_exner_hi = -32'sd200000;
        base.t_hat = 1 <<< 20;
        for (int m = 0; m < 4; m++)
        begin
            w = base;
            w.cmd = m[0];
            w.is_top = m[1];
            send_word(w);
        end
        for (int m = 0; m < 4; m++)
        begin
            w = base;
            w.cmd = m[0];
            w.is_top = m[1];
            w.hl_hi = w.hl_lo;
            send_word(w);
        end
        for (int m = 0; m < 4; m++)
        begin
            w = base;
            w.cmd = m[0];
            w.is_top = m[1];
            w.theta = '0;
            send_word(w);
        end
        for (int m = 0; m < 4; m++)
        begin
            w = base;
            w.cmd = m[0];
            w.is_top = m[1];
            w.h = maxv; w.hl_lo = minv; w.hl_hi = maxv;
            w.exner_lo = maxv; w.exner_hi = minv; w.theta = m[0] ? maxv : minv;
            w.inc_theta = maxv; w.inc_exner_lo = minv; w.inc_exner_hi = maxv;
            w.t_hat = minv;
            send_word(w);
        end
        for (int m = 0; m < 4; m++)
        begin
            w = base;
            w.cmd = m[0];
            w.is_top = m[1];
            w.theta = 32'sd1;
            w.hl_lo = minv; w.h = minv; w.hl_hi = minv + 1;
            w.t_hat = maxv; w.inc_theta = minv;
            send_word(w);
        end
        drain();
    endtask

    task automatic test_random(input int count, input bit with_gaps);
        int burst;
        int n;
        n = 0;
        while (n < count)
        begin
            burst = $urandom_range(1, 24);
            for (int i = 0; i < burst && n < count; i++)
            begin
                send_word(($urandom_range(0, 4) == 0) ? noise_word() : realistic_word());
                n++;
            end
            if (with_gaps && $urandom_range(0, 3) != 0)
            begin
                start <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
        end
        drain();
    endtask

    task automatic test_config_sweep();
        write_g('0);
        test_random(250, 1'b1);
        write_g({GW{1'b1}});
        test_random(250, 1'b1);
        write_g(GW'($urandom()));
        test_random(250, 1'b0);
        write_g(ati_pkg::G_OVER_CP_RESET);
        test_random(200, 1'b1);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word %h", result);
            end
            else
            begin
                ati_pkg::out_t e;
                e = expected_words.pop_front();
                words_checked++;
                if (result.fault)
                    faults_seen++;
                if (result !== e)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch t_inc %h/%h th %h/%h elo %h/%h ehi %h/%h f %b/%b",
                            e.t_inc, result.t_inc, e.theta_hat_add, result.theta_hat_add,
                            e.exner_lo_hat_add, result.exner_lo_hat_add,
                            e.exner_hi_hat_add, result.exner_hi_hat_add,
                            e.fault, result.fault);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        cfg_wr = 1'b0;
        cfg_data = '0;
        mismatches = 0;
        words_sent = 0;
        words_checked = 0;
        faults_seen = 0;
        cycles = 0;
        g_model = ati_pkg::G_OVER_CP_RESET;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(600, 1'b1);
        test_config_sweep();
        write_g(GW'(28'h5A5A5A5));
        test_random(300, 1'b1);
        if (expected_words.size() != 0)
            mismatches++;
        $display("%0d of %0d words checked in tangent and adjoint, top and interior, %0d faults",
            words_checked, words_sent, faults_seen);
        $display("g_over_cp swept through zero, all ones, random and default settings");
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
